@@ hdl/mprt_pkg.sv @@
// ---------------------------------------------------------------------------
// Metadata piece request tracker package
// Shared constants, codes and transaction types of the piece request tracker.
// ---------------------------------------------------------------------------
`default_nettype none

package mprt_pkg;

   // Sizing of the needed-piece list.
   localparam int MAX_PIECES  = 64;
   localparam int PIECE_BYTES = 16384;
   localparam int DEFAULT_REPEAT_SECS = 3;

   localparam int PIECE_SHIFT = $clog2(PIECE_BYTES);
   localparam int PIECE_W     = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
   localparam int CNT_W       = $clog2(MAX_PIECES + 1);
   localparam int TIME_W      = 32;
   localparam int INDEX_W     = 16;
   localparam int LENGTH_W    = 15;
   localparam int SIZE_W      = 21;
   localparam int BAD_W       = 9;
   localparam int BYTE_W      = 8;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_METADATA_SIZE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_BAD_PIECES  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INTERVAL = 2'd2;

   typedef enum logic [1:0] {
      REQ_START   = 2'd0,
      REQ_NEXT    = 2'd1,
      REQ_PIECE   = 2'd2,
      REQ_VERDICT = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_NOTHING   = 4'd0,
      ST_REQUEST   = 4'd1,
      ST_ACCEPTED  = 4'd2,
      ST_UNNEEDED  = 4'd3,
      ST_BAD       = 4'd4,
      ST_VERIFY    = 4'd5,
      ST_DONE      = 4'd6,
      ST_RETRY     = 4'd7,
      ST_DISABLED  = 4'd8,
      ST_SETUPFAIL = 4'd9,
      ST_BADLIMIT  = 4'd10,
      ST_BLOCKSIZE = 4'd11,
      ST_PARSEFAIL = 4'd12,
      ST_INACTIVE  = 4'd13
   } status_type;

   typedef enum logic [3:0] {
      PH_INACTIVE = 4'b0001,
      PH_TRACK    = 4'b0010,
      PH_VERIFY   = 4'b0100,
      PH_DONE     = 4'b1000
   } phase_type;

   // Operation applied to every cell of the row in the same cycle.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_FILL   = 2'd1,
      OP_ROTATE = 2'd2,
      OP_REMOVE = 2'd3
   } cell_op_type;

   typedef struct packed {
      logic [1:0]          req_type;
      logic [TIME_W-1:0]   now_secs;
      logic [INDEX_W-1:0]  piece_index;
      logic [LENGTH_W-1:0] piece_length;
      logic [31:0]         total_size;
      logic                checksum_ok;
      logic                info_ok;
      logic                block_size_ok;
   } req_item_type;

   typedef struct packed {
      logic [3:0]         status;
      logic               piece_issued;
      logic [5:0]         requested_piece;
      logic [6:0]         pieces_remaining;
      logic [6:0]         pieces_total;
      logic [BAD_W-1:0]   bad_count_out;
      logic               tracking_active;
   } rsp_item_type;

   // Broadcast control shared by every list cell.
   typedef struct packed {
      cell_op_type         op;
      logic [CNT_W-1:0]    count;
      logic [PIECE_W-1:0]  last;
      logic [INDEX_W-1:0]  look_index;
      logic [PIECE_W-1:0]  head_piece;
      logic [TIME_W-1:0]   now_time;
   } cell_ctl_type;

endpackage

`default_nettype wire

@@ hdl/mprt_cell.sv @@
// ---------------------------------------------------------------------------
// Metadata piece request tracker list cell
// Holds one list position (piece number and last request time).
// ---------------------------------------------------------------------------
`default_nettype none

module mprt_cell #(
   parameter int IDX = 0
) (
   input  wire logic                         clock,
   input  wire mprt_pkg::cell_ctl_type       ctl,
   input  wire logic                         shift_en,
   input  wire logic [mprt_pkg::PIECE_W-1:0] next_piece,
   input  wire logic [mprt_pkg::TIME_W-1:0]  next_time,
   output logic      [mprt_pkg::PIECE_W-1:0] piece_out,
   output logic      [mprt_pkg::TIME_W-1:0]  time_out,
   output logic                              match_out
);
   import mprt_pkg::*;

   logic [PIECE_W-1:0] piece_ff, piece_in;
   logic [TIME_W-1:0]  time_ff, time_in;
   logic               match_ff, match_in;
   logic               below_last;

   assign below_last = PIECE_W'(IDX) < ctl.last;

   always_comb begin
      piece_in = piece_ff;
      time_in  = time_ff;
      case (ctl.op)
         OP_FILL: begin
            piece_in = PIECE_W'(IDX);
            time_in  = '0;
         end
         OP_ROTATE: begin
            if (below_last) begin
               piece_in = next_piece;
               time_in  = next_time;
            end else if (PIECE_W'(IDX) == ctl.last) begin
               piece_in = ctl.head_piece;
               time_in  = ctl.now_time;
            end
         end
         OP_REMOVE: begin
            if (shift_en && below_last) begin
               piece_in = next_piece;
               time_in  = next_time;
            end
         end
         default: begin
         end
      endcase
   end

   // Only live positions may report a hit.
   assign match_in = (CNT_W'(IDX) < ctl.count) && (INDEX_W'(piece_ff) == ctl.look_index);

   always_ff @(posedge clock) begin
      piece_ff <= piece_in;
      time_ff  <= time_in;
      match_ff <= match_in;
   end

   assign piece_out = piece_ff;
   assign time_out  = time_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

@@ hdl/metadata_piece_request_tracker.sv @@
// ---------------------------------------------------------------------------
// Metadata piece request tracker
// Keeps the ordered list of metadata pieces still needed and answers start,
// request, piece and verdict transactions with one result each.
// ---------------------------------------------------------------------------
// The tracker returns one result for each transaction, in order. In the
// look state every list cell compares its piece against the arrived piece
// index, and the head entry's request time and the piece's size limits are
// checked; the exec state commits the update to the row of cells and loads
// the output register. That compare-then-shift pass over the cell row sets
// the pace: a new transaction is taken while idle or as the last commits.
// While the output register still holds an untaken result, the next
// transaction is accepted and worked up to its commit, which then waits for
// the output to free. The list itself needs no clearing pass after reset:
// it is always filled by a start transaction before it is read. The
// configuration port is always ready and must only be written while the
// tracker is idle.
`default_nettype none

module metadata_piece_request_tracker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire mprt_pkg::req_item_type          req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output mprt_pkg::rsp_item_type               rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mprt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mprt_pkg::SIZE_W-1:0]     csr_data
);
   import mprt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_LOOK = 3'b010,
      S_EXEC = 3'b100
   } state_type;

   localparam int N_W   = SIZE_W + 1 - PIECE_SHIFT;
   localparam int OFF_W = INDEX_W + PIECE_SHIFT + 1;

   // Sequencer and transaction register.
   state_type    state_ff, state_in;
   req_item_type item_ff;
   logic         accept, exec_go;

   // Configuration registers.
   logic [SIZE_W-1:0] meta_size_ff;
   logic [BYTE_W-1:0] max_bad_ff;
   logic [BYTE_W-1:0] repeat_ff;

   // Tracking state.
   logic [CNT_W-1:0]  needed_ff, needed_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [BAD_W-1:0]  bad_ff, bad_in, bad_inc;
   phase_type         phase_ff, phase_in;
   logic              setup_ff, setup_in;
   logic [SIZE_W-1:0] tracked_ff, tracked_in;

   // Values computed in the look cycle.
   logic head_due_ff, bounds_bad_ff;

   // Cell row.
   cell_ctl_type       cell_ctl;
   cell_op_type        op_sel;
   logic [PIECE_W-1:0] piece_vec [MAX_PIECES+1];
   logic [TIME_W-1:0]  time_vec  [MAX_PIECES+1];
   logic [MAX_PIECES-1:0] match_vec, shift_vec;
   logic               found;

   // Start sizing.
   logic [SIZE_W:0]  size_round;
   logic [N_W-1:0]   n_pieces;
   logic             size_bad;

   // Result.
   rsp_item_type rsp_in, rsp_data_ff;
   logic         rsp_valid_ff;
   status_type   st;
   logic         disabled;

   // ------------------------------------------------------------------
   // Handshakes and sequencing. An item is accepted when the sequencer is
   // idle, or in the very cycle that the previous item commits.
   // ------------------------------------------------------------------
   assign exec_go   = (state_ff == S_EXEC) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || !((state_ff == S_IDLE) || exec_go);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) begin
            state_in = S_LOOK;
         end
         S_LOOK: begin
            state_in = S_EXEC;
         end
         S_EXEC: if (exec_go) begin
            state_in = accept ? S_LOOK : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
   end

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         meta_size_ff <= '0;
         max_bad_ff   <= BYTE_W'(4);
         repeat_ff    <= BYTE_W'(DEFAULT_REPEAT_SECS);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_METADATA_SIZE:   meta_size_ff <= csr_data;
            CSR_MAX_BAD_PIECES:  max_bad_ff   <= csr_data[BYTE_W-1:0];
            CSR_REPEAT_INTERVAL: repeat_ff    <= csr_data[BYTE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Row of list cells. Each cell takes its successor's entry when the
   // list closes up, and the head entry is broadcast to the tail slot on
   // a request.
   // ------------------------------------------------------------------
   assign piece_vec[MAX_PIECES] = '0;
   assign time_vec[MAX_PIECES]  = '0;

   for (genvar k = 0; k < MAX_PIECES; k++) begin : g_cell
      mprt_cell #(
         .IDX(k)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .shift_en   (shift_vec[k]),
         .next_piece (piece_vec[k+1]),
         .next_time  (time_vec[k+1]),
         .piece_out  (piece_vec[k]),
         .time_out   (time_vec[k]),
         .match_out  (match_vec[k])
      );
   end

   // Pieces in the list are unique, so at most one cell matches; every
   // position from the match onward closes up.
   assign shift_vec = ~(match_vec - MAX_PIECES'(1));
   assign found     = |match_vec;

   assign cell_ctl.op         = op_sel;
   assign cell_ctl.count      = needed_ff;
   assign cell_ctl.last       = PIECE_W'(needed_ff - CNT_W'(1));
   assign cell_ctl.look_index = item_ff.piece_index;
   assign cell_ctl.head_piece = piece_vec[0];
   assign cell_ctl.now_time   = item_ff.now_secs;

   // ------------------------------------------------------------------
   // Look cycle: head age and piece size limits, registered.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      head_due_ff   <= ((TIME_W+1)'(time_vec[0]) + (TIME_W+1)'(repeat_ff))
                       < (TIME_W+1)'(item_ff.now_secs);
      bounds_bad_ff <= (((OFF_W'(item_ff.piece_index) << PIECE_SHIFT)
                         + OFF_W'(item_ff.piece_length)) > OFF_W'(tracked_ff))
                       || (32'(tracked_ff) > item_ff.total_size);
   end

   // ------------------------------------------------------------------
   // Commit cycle.
   // ------------------------------------------------------------------
   assign size_round = (SIZE_W+1)'(meta_size_ff) + (SIZE_W+1)'(PIECE_BYTES - 1);
   assign n_pieces   = size_round[SIZE_W:PIECE_SHIFT];
   assign size_bad   = (meta_size_ff == '0) || (n_pieces > N_W'(MAX_PIECES));
   assign bad_inc    = bad_ff + BAD_W'(1);
   assign disabled   = (max_bad_ff == '0) || ((max_bad_ff == BYTE_W'(1)) && setup_ff);

   always_comb begin
      needed_in  = needed_ff;
      total_in   = total_ff;
      bad_in     = bad_ff;
      phase_in   = phase_ff;
      setup_in   = setup_ff;
      tracked_in = tracked_ff;
      op_sel     = OP_HOLD;
      st         = ST_NOTHING;
      rsp_in     = '0;
      if (state_ff == S_EXEC) begin
         case (item_ff.req_type)
            REQ_START: begin
               if (phase_ff == PH_INACTIVE) begin
                  bad_in   = '0;
                  phase_in = PH_TRACK;
                  op_sel   = OP_FILL;
                  if (size_bad) begin
                     setup_in   = 1'b1;
                     tracked_in = '0;
                     total_in   = '0;
                  end else begin
                     setup_in   = 1'b0;
                     tracked_in = meta_size_ff;
                     total_in   = CNT_W'(n_pieces);
                  end
                  needed_in = total_in;
               end
            end
            REQ_NEXT, REQ_PIECE: begin
               if (phase_ff inside {PH_INACTIVE, PH_DONE}) begin
                  st = ST_INACTIVE;
               end else if (phase_ff == PH_TRACK) begin
                  if (disabled || setup_ff) begin
                     // The list is dropped when the tracker is disabled or
                     // the start could not size the metadata.
                     needed_in = '0;
                     total_in  = '0;
                     phase_in  = PH_INACTIVE;
                     st        = disabled ? ST_DISABLED : ST_SETUPFAIL;
                  end else if (item_ff.req_type == REQ_NEXT) begin
                     if ((needed_ff != '0) && head_due_ff) begin
                        op_sel = OP_ROTATE;
                        st     = ST_REQUEST;
                     end
                  end else if (bounds_bad_ff) begin
                     bad_in = bad_inc;
                     if (bad_inc > BAD_W'(max_bad_ff)) begin
                        needed_in = '0;
                        total_in  = '0;
                        phase_in  = PH_INACTIVE;
                        st        = ST_BADLIMIT;
                     end else begin
                        st = ST_BAD;
                     end
                  end else if (!found) begin
                     st = ST_UNNEEDED;
                  end else begin
                     op_sel    = OP_REMOVE;
                     needed_in = needed_ff - CNT_W'(1);
                     if (needed_ff == CNT_W'(1)) begin
                        phase_in = PH_VERIFY;
                        st       = ST_VERIFY;
                     end else begin
                        st = ST_ACCEPTED;
                     end
                  end
               end
            end
            REQ_VERDICT: begin
               if (phase_ff == PH_VERIFY) begin
                  if (item_ff.checksum_ok && item_ff.info_ok && item_ff.block_size_ok) begin
                     phase_in  = PH_DONE;
                     needed_in = '0;
                     st        = ST_DONE;
                  end else if (item_ff.checksum_ok) begin
                     needed_in = '0;
                     total_in  = '0;
                     phase_in  = PH_INACTIVE;
                     st        = item_ff.info_ok ? ST_BLOCKSIZE : ST_PARSEFAIL;
                  end else begin
                     bad_in = bad_inc;
                     if (bad_inc > BAD_W'(max_bad_ff)) begin
                        needed_in = '0;
                        total_in  = '0;
                        phase_in  = PH_INACTIVE;
                        st        = ST_BADLIMIT;
                     end else begin
                        // A failed hash refills the whole list and starts over.
                        op_sel    = OP_FILL;
                        needed_in = total_ff;
                        phase_in  = PH_TRACK;
                        st        = ST_RETRY;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
         if (!exec_go) begin
            op_sel = OP_HOLD;
         end
      end
      rsp_in.status           = st;
      rsp_in.piece_issued     = (st == ST_REQUEST);
      rsp_in.requested_piece  = (st == ST_REQUEST) ? 6'(piece_vec[0]) : 6'd0;
      rsp_in.pieces_remaining = 7'(needed_in);
      rsp_in.pieces_total     = 7'(total_in);
      rsp_in.bad_count_out    = bad_in;
      rsp_in.tracking_active  = (phase_in == PH_TRACK) || (phase_in == PH_VERIFY);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needed_ff  <= '0;
         total_ff   <= '0;
         bad_ff     <= '0;
         phase_ff   <= PH_INACTIVE;
         setup_ff   <= 1'b0;
         tracked_ff <= '0;
      end else if (exec_go) begin
         needed_ff  <= needed_in;
         total_ff   <= total_in;
         bad_ff     <= bad_in;
         phase_ff   <= phase_in;
         setup_ff   <= setup_in;
         tracked_ff <= tracked_in;
      end
   end

   // ------------------------------------------------------------------
   // Output register: a result stays until the receiver takes it.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (exec_go) begin
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_needed_le_total: assert property (@(posedge clock) disable iff (reset)
      needed_ff <= total_ff)
      else $error("needed piece count exceeds piece total");

   a_verify_empty: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_VERIFY) |-> (needed_ff == '0))
      else $error("awaiting verdict with pieces still needed");

   a_rotate_nonempty: assert property (@(posedge clock) disable iff (reset)
      (op_sel == OP_ROTATE) |-> (needed_ff != '0))
      else $error("request rotation on an empty list");

   a_remove_unique: assert property (@(posedge clock) disable iff (reset)
      (op_sel == OP_REMOVE) |-> $onehot(match_vec))
      else $error("piece removal without exactly one matching cell");

   a_accept_to_look: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_LOOK))
      else $error("accepted transaction did not enter the look cycle");

endmodule

`default_nettype wire

@@ tb/metadata_piece_request_tracker_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Metadata piece request tracker testbench
// Drives start, request, piece and verdict transactions with random gaps and
// back-pressure. It predicts every result with its own model of the needed-
// piece list and compares the results field by field, in order.
// ---------------------------------------------------------------------------

module metadata_piece_request_tracker_test;

   import mprt_pkg::*;

   // Prediction and checking. The class keeps its own copy of the list, the
   // counters and the registers. Each accepted transaction is run through the
   // same rules as the tracker, and the outcome is queued until the matching
   // result comes back.
   class tracker_scoreboard;
      logic [SIZE_W-1:0] size_reg;
      logic [7:0]        max_bad_reg;
      logic [7:0]        interval_reg;

      logic [PIECE_W-1:0] order_piece [MAX_PIECES];
      logic [TIME_W-1:0]  order_time [MAX_PIECES];
      int                 needed_count;
      int                 piece_total;
      int                 bad_count;
      phase_type          phase;
      bit                 setup_failed;
      logic [SIZE_W-1:0]  tracked_size;

      rsp_item_type       awaited_outcomes[$];
      int                 failures;

      function new();
         size_reg = '0;
         max_bad_reg = 8'd4;
         interval_reg = 8'(DEFAULT_REPEAT_SECS);
         for (int i = 0; i < MAX_PIECES; i++) begin
            order_piece[i] = '0;
            order_time[i] = '0;
         end
         needed_count = 0;
         piece_total = 0;
         bad_count = 0;
         phase = PH_INACTIVE;
         setup_failed = 1'b0;
         tracked_size = '0;
         failures = 0;
      endfunction

      function void write_register(logic [CSR_INDEX_W-1:0] idx, logic [SIZE_W-1:0] value);
         case (idx)
            CSR_METADATA_SIZE:   size_reg = value;
            CSR_MAX_BAD_PIECES:  max_bad_reg = value[7:0];
            CSR_REPEAT_INTERVAL: interval_reg = value[7:0];
            default: ;
         endcase
      endfunction

      // Every piece of the current size is needed again, all of them
      // unrequested so far.
      function void refill();
         for (int i = 0; i < piece_total; i++) begin
            order_piece[i] = PIECE_W'(i);
            order_time[i] = '0;
         end
         needed_count = piece_total;
      endfunction

      function void abort();
         needed_count = 0;
         piece_total = 0;
         phase = PH_INACTIVE;
      endfunction

      function int outstanding();
         return awaited_outcomes.size();
      endfunction

      function void note_item(req_item_type it);
         status_type         st;
         bit                 have;
         logic [5:0]         reqp;
         logic [PIECE_W-1:0] head;
         logic [63:0]        head_due;
         logic [63:0]        now_wide;
         logic [63:0]        offset;
         int                 slot;
         int                 pieces;
         int                 i;
         rsp_item_type       outcome;

         st = ST_NOTHING;
         have = 1'b0;
         reqp = '0;
         case (it.req_type)
            REQ_START: begin
               // A start only counts while nothing is being tracked.
               if (phase == PH_INACTIVE) begin
                  pieces = (int'(size_reg) + PIECE_BYTES - 1) / PIECE_BYTES;
                  bad_count = 0;
                  phase = PH_TRACK;
                  if (size_reg == 0 || pieces > MAX_PIECES) begin
                     setup_failed = 1'b1;
                     tracked_size = '0;
                     piece_total = 0;
                  end else begin
                     setup_failed = 1'b0;
                     tracked_size = size_reg;
                     piece_total = pieces;
                  end
                  refill();
               end
            end
            REQ_NEXT, REQ_PIECE: begin
               if (phase == PH_INACTIVE || phase == PH_DONE) begin
                  st = ST_INACTIVE;
               end else if (phase == PH_TRACK) begin
                  if (max_bad_reg == 0 || (max_bad_reg == 1 && setup_failed)) begin
                     abort();
                     st = ST_DISABLED;
                  end else if (setup_failed) begin
                     abort();
                     st = ST_SETUPFAIL;
                  end else if (it.req_type == REQ_NEXT) begin
                     // The head goes out again only once its repeat interval
                     // has fully passed; the sum is wide so it never wraps.
                     head_due = 64'(order_time[0]) + 64'(interval_reg);
                     now_wide = 64'(it.now_secs);
                     if (needed_count > 0 && head_due < now_wide) begin
                        head = order_piece[0];
                        for (i = 1; i < needed_count; i++) begin
                           order_piece[i-1] = order_piece[i];
                           order_time[i-1] = order_time[i];
                        end
                        order_piece[needed_count-1] = head;
                        order_time[needed_count-1] = it.now_secs;
                        st = ST_REQUEST;
                        have = 1'b1;
                        reqp = 6'(head);
                     end
                  end else begin
                     offset = 64'(it.piece_index) * 64'(PIECE_BYTES);
                     if (offset + 64'(it.piece_length) > 64'(tracked_size) ||
                         64'(tracked_size) > 64'(it.total_size)) begin
                        bad_count++;
                        if (bad_count > max_bad_reg) begin
                           abort();
                           st = ST_BADLIMIT;
                        end else begin
                           st = ST_BAD;
                        end
                     end else begin
                        slot = -1;
                        for (i = 0; i < needed_count; i++)
                           if (slot < 0 && 16'(order_piece[i]) == it.piece_index) slot = i;
                        if (slot < 0) begin
                           st = ST_UNNEEDED;
                        end else begin
                           for (i = slot; i + 1 < needed_count; i++) begin
                              order_piece[i] = order_piece[i+1];
                              order_time[i] = order_time[i+1];
                           end
                           needed_count--;
                           if (needed_count == 0) begin
                              phase = PH_VERIFY;
                              st = ST_VERIFY;
                           end else begin
                              st = ST_ACCEPTED;
                           end
                        end
                     end
                  end
               end
            end
            default: begin
               if (phase == PH_VERIFY) begin
                  if (it.checksum_ok && it.info_ok && it.block_size_ok) begin
                     phase = PH_DONE;
                     needed_count = 0;
                     st = ST_DONE;
                  end else if (it.checksum_ok && it.info_ok) begin
                     abort();
                     st = ST_BLOCKSIZE;
                  end else if (it.checksum_ok) begin
                     abort();
                     st = ST_PARSEFAIL;
                  end else begin
                     // A failed hash counts as one more bad attempt.
                     bad_count++;
                     if (bad_count > max_bad_reg) begin
                        abort();
                        st = ST_BADLIMIT;
                     end else begin
                        refill();
                        phase = PH_TRACK;
                        st = ST_RETRY;
                     end
                  end
               end
            end
         endcase

         outcome.status = st;
         outcome.piece_issued = have;
         outcome.requested_piece = reqp;
         outcome.pieces_remaining = 7'(needed_count);
         outcome.pieces_total = 7'(piece_total);
         outcome.bad_count_out = BAD_W'(bad_count);
         outcome.tracking_active = (phase == PH_TRACK || phase == PH_VERIFY);
         awaited_outcomes.push_back(outcome);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            failures++;
         end
      endfunction

      function void check_outcome(rsp_item_type got);
         rsp_item_type want;
         if (awaited_outcomes.size() == 0) begin
            $error("result with status %0d arrived while none was outstanding", got.status);
            failures++;
            return;
         end
         want = awaited_outcomes.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("piece_issued", 32'(want.piece_issued), 32'(got.piece_issued));
         compare_field("requested_piece", 32'(want.requested_piece),
                       32'(got.requested_piece));
         compare_field("pieces_remaining", 32'(want.pieces_remaining),
                       32'(got.pieces_remaining));
         compare_field("pieces_total", 32'(want.pieces_total), 32'(got.pieces_total));
         compare_field("bad_count_out", 32'(want.bad_count_out), 32'(got.bad_count_out));
         compare_field("tracking_active", 32'(want.tracking_active),
                       32'(got.tracking_active));
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_item_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_item_type           rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [SIZE_W-1:0]      csr_data;

   tracker_scoreboard board = new();

   // Shared between the stimulus and the result sink. The stimulus raises
   // long_hold_req and the sink counts the hold-off itself.
   bit          long_hold_req = 1'b0;
   int          burst_left = 0;
   logic [31:0] clock_secs = 32'd10;

   metadata_piece_request_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Generous limit: far above the slowest legal run with every gap and
   // every stall at its longest.
   initial begin
      #10_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Result sink. It checks each accepted result and then picks the stall
   // for the next cycle: mostly short runs, a few long ones, some stretches
   // with no stall at all, and the long hold-off when asked for.
   initial begin : result_sink
      int stall_left;
      int open_left;
      int hold_left;
      int roll;
      stall_left = 0;
      open_left = 0;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_outcome(rsp_data);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (stall_left == 0 && open_left == 0) begin
               roll = $urandom_range(0, 99);
               if (roll < 15) open_left = $urandom_range(30, 120);
               else if (roll < 60) open_left = $urandom_range(1, 4);
               else if (roll < 90) stall_left = $urandom_range(1, 3);
               else if (roll < 97) stall_left = $urandom_range(4, 12);
               else stall_left = $urandom_range(20, 60);
            end
            if (stall_left > 0) begin
               stall_left--;
               rsp_stall <= 1'b1;
            end else begin
               if (open_left > 0) open_left--;
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Sender gap in cycles: mostly none or short, now and then long. A burst
   // forces back-to-back transactions.
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 50);
   endfunction

   // A transaction of the given kind with every other field random.
   function automatic req_item_type shaped(req_kind_type kind);
      logic [127:0] junk;
      req_item_type it;
      junk = {$urandom, $urandom, $urandom, $urandom};
      it = junk[$bits(req_item_type)-1:0];
      it.req_type = kind;
      return it;
   endfunction

   // Gives a piece transaction the given index, a length that fits the
   // tracked size and an announced total at or above it.
   function automatic req_item_type fit_piece(req_item_type it, int idx);
      int room;
      int most;
      it.piece_index = 16'(idx);
      room = int'(board.tracked_size) - idx * PIECE_BYTES;
      most = (room < PIECE_BYTES) ? room : PIECE_BYTES;
      it.piece_length = ($urandom_range(0, 1) != 0) ? LENGTH_W'(most)
                                                    : LENGTH_W'($urandom_range(0, most));
      if ($urandom_range(0, 9) < 7) it.total_size = 32'(board.tracked_size);
      else it.total_size = 32'(board.tracked_size) + $urandom_range(0, 1 << 20);
      return it;
   endfunction

   // Next transaction, shaped by where the predicted state stands so that
   // most traffic walks the list through to verification. A share of pure
   // noise keeps every field bit moving. Before the closing stretch a good
   // verdict is never sent, since done can only be left by a reset.
   function automatic req_item_type plan_item(bit finish_run);
      req_item_type it;
      logic [127:0] junk;
      int           roll;
      int           pick;
      int           last;
      int           most;
      roll = $urandom_range(0, 99);
      if (!finish_run && roll < 8) begin
         junk = {$urandom, $urandom, $urandom, $urandom};
         it = junk[$bits(req_item_type)-1:0];
         if (it.req_type == REQ_VERDICT && it.checksum_ok && it.info_ok)
            it.block_size_ok = 1'b0;
         return it;
      end
      case (board.phase)
         PH_INACTIVE: it = shaped(REQ_START);
         PH_TRACK: begin
            if (roll < 35 || board.needed_count == 0 || board.setup_failed) begin
               it = shaped(REQ_NEXT);
               pick = $urandom_range(0, 99);
               if (pick < 40) clock_secs += $urandom_range(0, 2);
               else if (pick < 85) clock_secs += $urandom_range(0, 2 * board.interval_reg + 4);
               else if (pick < 95) clock_secs += $urandom_range(0, 100000);
               else clock_secs = $urandom;
               it.now_secs = clock_secs;
            end else if (roll < 80) begin
               pick = board.order_piece[$urandom_range(0, board.needed_count - 1)];
               it = fit_piece(shaped(REQ_PIECE), pick);
            end else if (roll < 90) begin
               // Often a piece that already came in.
               it = fit_piece(shaped(REQ_PIECE), $urandom_range(0, board.piece_total - 1));
            end else begin
               it = shaped(REQ_PIECE);
               last = board.piece_total - 1;
               pick = $urandom_range(0, 2);
               if (pick == 0) begin
                  it.piece_index = 16'($urandom_range(board.piece_total, 65535));
               end else if (pick == 1) begin
                  it = fit_piece(it, board.order_piece[0]);
                  it.total_size = $urandom_range(0, int'(board.tracked_size) - 1);
               end else begin
                  it = fit_piece(it, last);
                  most = int'(board.tracked_size) - last * PIECE_BYTES;
                  it.piece_length = LENGTH_W'($urandom_range(most + 1, 32767));
               end
            end
         end
         PH_VERIFY: begin
            it = shaped(REQ_VERDICT);
            pick = $urandom_range(0, 99);
            if (finish_run) begin
               it.checksum_ok = 1'b1;
               it.info_ok = 1'b1;
               it.block_size_ok = 1'b1;
            end else if (pick < 60) begin
               it.checksum_ok = 1'b0;
            end else if (pick < 80) begin
               it.checksum_ok = 1'b1;
               it.info_ok = 1'b0;
            end else begin
               it.checksum_ok = 1'b1;
               it.info_ok = 1'b1;
               it.block_size_ok = 1'b0;
            end
         end
         default: it = shaped(REQ_NEXT);
      endcase
      return it;
   endfunction

   // Offers one transaction and returns at the edge that accepts it. Valid
   // stays high afterwards so that a following transaction can go out
   // without a gap.
   task automatic send_item(req_item_type it);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (req_stall);
      board.note_item(it);
   endtask

   // Stops offering and waits until every outstanding result has come back
   // and the tracker is fully idle.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Leaves csr_valid high; apply_settings lowers it after the last write.
   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [SIZE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_register(idx, value);
   endtask

   // The narrow registers get random upper bits, which must be ignored.
   task automatic apply_settings(logic [SIZE_W-1:0] size, logic [7:0] max_bad,
                                 logic [7:0] interval);
      csr_write(CSR_METADATA_SIZE, size);
      csr_write(CSR_MAX_BAD_PIECES, {13'($urandom), max_bad});
      csr_write(CSR_REPEAT_INTERVAL, {13'($urandom), interval});
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      req_item_type      it;
      logic [SIZE_W-1:0] size;
      logic [7:0]        max_bad;
      logic [7:0]        interval;
      int                roll;
      int                guard;

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_METADATA_SIZE;
      csr_data <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Registers hold their reset values at first: size
      // zero, four bad pieces allowed, a repeat interval of three seconds.
      it = shaped(REQ_NEXT);
      it.now_secs = '1;
      send_item(it);                 // request while nothing is tracked
      it = shaped(REQ_PIECE);
      it.piece_index = '1;
      it.piece_length = '1;
      it.total_size = '1;
      send_item(it);                 // piece while nothing is tracked
      it = shaped(REQ_VERDICT);
      it.checksum_ok = 1'b1;
      it.info_ok = 1'b1;
      it.block_size_ok = 1'b1;
      send_item(it);                 // verdict with no verification pending
      send_item(shaped(REQ_START));  // zero size is a setup failure
      send_item(shaped(REQ_START));  // start while already started is ignored
      it = shaped(REQ_NEXT);
      it.now_secs = 32'd100;
      send_item(it);                 // reports the setup failure and drops

      // One bad piece allowed plus a setup failure disables the tracker.
      wait_for_results();
      apply_settings('0, 8'd1, 8'd3);
      send_item(shaped(REQ_START));
      send_item(shaped(REQ_PIECE));

      // One piece past the limit of the list, with the tracker disabled.
      wait_for_results();
      apply_settings(21'd1048577, 8'd0, 8'd3);
      send_item(shaped(REQ_START));
      it = shaped(REQ_NEXT);
      it.now_secs = 32'd1000;
      send_item(it);

      // Full list of pieces, zero repeat interval, two bad pieces allowed.
      wait_for_results();
      apply_settings(21'd1048576, 8'd2, 8'd0);
      send_item(shaped(REQ_START));
      it = shaped(REQ_NEXT);
      it.now_secs = 32'd1;
      send_item(it);
      it.now_secs = '1;
      send_item(it);                 // latest possible time, no wrap
      it = shaped(REQ_PIECE);
      it.piece_index = 16'd63;
      it.piece_length = LENGTH_W'(PIECE_BYTES);
      it.total_size = 32'd1048576;
      send_item(it);                 // last piece, exactly at the size limit
      send_item(it);                 // same piece again is no longer needed
      it.piece_index = 16'd1;
      it.piece_length = '0;
      it.total_size = 32'd1048575;
      send_item(it);                 // peer announces too small a total
      it.piece_index = '1;
      it.total_size = '0;
      send_item(it);
      it.piece_index = 16'd63;
      it.piece_length = LENGTH_W'(PIECE_BYTES + 1);
      it.total_size = 32'd1048576;
      send_item(it);                 // third bad piece passes the limit

      // A single one-byte piece with the widest repeat interval.
      wait_for_results();
      apply_settings(21'd1, 8'd255, 8'd255);
      send_item(shaped(REQ_START));
      it = shaped(REQ_NEXT);
      it.now_secs = 32'd255;
      send_item(it);                 // interval not yet passed
      it.now_secs = 32'd256;
      send_item(it);
      it = shaped(REQ_PIECE);
      it.piece_index = '0;
      it.piece_length = LENGTH_W'(1);
      it.total_size = 32'd1;
      send_item(it);                 // last needed piece asks for verification
      send_item(shaped(REQ_NEXT));   // no change while the verdict is pending
      send_item(shaped(REQ_START));
      it = shaped(REQ_VERDICT);
      it.checksum_ok = 1'b0;
      send_item(it);                 // failed hash refills the list

      // Random part: a dozen settings, each for about a hundred transactions.
      // Sizes stay small most of the time so the list empties often.
      for (int s = 0; s < 12; s++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) size = SIZE_W'($urandom_range(1, 4 * PIECE_BYTES));
         else if (roll < 80) size = SIZE_W'($urandom_range(1, MAX_PIECES * PIECE_BYTES));
         else if (roll < 85) size = SIZE_W'(MAX_PIECES * PIECE_BYTES);
         else if (roll < 90) size = '0;
         else if (roll < 95) size = '1;
         else size = SIZE_W'($urandom_range(1, 3) * PIECE_BYTES);
         roll = $urandom_range(0, 99);
         if (roll < 40) max_bad = 8'($urandom_range(1, 6));
         else if (roll < 60) max_bad = 8'd255;
         else if (roll < 70) max_bad = 8'd0;
         else if (roll < 80) max_bad = 8'd1;
         else max_bad = 8'($urandom);
         roll = $urandom_range(0, 99);
         if (roll < 30) interval = 8'd0;
         else if (roll < 60) interval = 8'($urandom_range(1, 5));
         else if (roll < 70) interval = 8'd255;
         else interval = 8'($urandom);
         wait_for_results();
         apply_settings(size, max_bad, interval);
         if ($urandom_range(0, 4) == 0) burst_left = 40;
         for (int k = 0; k < 100; k++) begin
            // Two sessions hold off the results for a long stretch while
            // transactions keep coming back to back, so the input backs up.
            if ((s == 1 || s == 6) && k == 10) begin
               long_hold_req = 1'b1;
               burst_left = 40;
            end
            if (s == 3 && k == 50) wait_for_results();
            send_item(plan_item(1'b0));
         end
      end

      // Closing stretch: walk one small list through to a good verdict, then
      // show that nothing moves the tracker once it is done.
      wait_for_results();
      apply_settings(SIZE_W'(3 * PIECE_BYTES - 100), 8'd255, 8'd0);
      guard = 0;
      while (board.phase != PH_DONE && guard < 500) begin
         send_item(plan_item(1'b1));
         guard++;
      end
      send_item(shaped(REQ_NEXT));
      send_item(shaped(REQ_PIECE));
      send_item(shaped(REQ_START));
      send_item(shaped(REQ_VERDICT));

      wait_for_results();
      repeat (20) @(posedge clock);
      if (board.failures == 0 && board.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
